>>> rtl/csr_to_hybrid_ell_coo_splitter_defines.svh
// Assertion helpers shared by the splitter modules.
// Every module that uses them names its clock "clock" and its reset "reset".
`ifndef CSR_TO_HYBRID_ELL_COO_SPLITTER_DEFINES_SVH
`define CSR_TO_HYBRID_ELL_COO_SPLITTER_DEFINES_SVH

// Expression must hold at every edge outside reset.
`define CSR2HYB_ASSERT(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Same-cycle implication.
`define CSR2HYB_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define CSR2HYB_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/csr2hyb_pkg.sv
package csr2hyb_pkg;

   localparam int MAX_ELL_WIDTH  = 16;
   localparam int INDEX_BITS     = 32;
   localparam int VALUE_BITS     = 64;
   localparam int ROW_BITS       = INDEX_BITS - 1;
   localparam int COL_IN_BITS    = INDEX_BITS - 1;
   localparam int WIDTH_BITS     = 5;
   localparam int STRIDE_BITS    = 31;
   localparam int PROD_BITS      = INDEX_BITS + WIDTH_BITS;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 31;

   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ELL_WIDTH   = 2'd0,
      CSR_SLOT_STRIDE = 2'd1
   } csr_index_type;

   typedef enum logic {
      FUNC_ENTRY   = 1'b0,
      FUNC_END_ROW = 1'b1
   } func_type;

   typedef enum logic {
      TARGET_ELL = 1'b0,
      TARGET_COO = 1'b1
   } target_type;

   // One queued command: a single write, or a run of padding writes.
   typedef struct packed {
      logic                   pad;
      target_type             target;
      logic [INDEX_BITS-1:0]  addr;
      logic [ROW_BITS-1:0]    row;
      logic [INDEX_BITS-1:0]  column;
      logic [VALUE_BITS-1:0]  value;
      logic [WIDTH_BITS-1:0]  count;
   } cmd_type;

endpackage

>>> rtl/csr2hyb_front.sv
`include "csr_to_hybrid_ell_coo_splitter_defines.svh"

module csr2hyb_front
   import csr2hyb_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_func,
   input  logic [COL_IN_BITS-1:0]  req_column_in,
   input  logic [VALUE_BITS-1:0]   req_entry_bits,
   input  logic [WIDTH_BITS-1:0]   ell_width,
   input  logic [STRIDE_BITS-1:0]  slot_stride,
   input  logic                    queue_full,
   output logic                    push,
   output cmd_type                 push_cmd
);

   logic [INDEX_BITS-1:0] row_ff, row_in;
   logic [INDEX_BITS-1:0] pos_ff, pos_in;
   logic [INDEX_BITS-1:0] coo_ff, coo_in;

   logic                  accept;
   logic [WIDTH_BITS-1:0] width_eff;
   logic                  is_ell;
   logic [PROD_BITS-1:0]  prod;
   logic [INDEX_BITS-1:0] ell_addr;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      width_eff = (int'(ell_width) > MAX_ELL_WIDTH) ? WIDTH_BITS'(MAX_ELL_WIDTH) : ell_width;
      is_ell    = pos_ff < INDEX_BITS'(width_eff);
      // only meaningful while is_ell, so the low position bits suffice
      prod      = PROD_BITS'(slot_stride) * PROD_BITS'(pos_ff[WIDTH_BITS-1:0]);
      ell_addr  = row_ff + prod[INDEX_BITS-1:0];
   end

   always_comb begin
      row_in          = row_ff;
      pos_in          = pos_ff;
      coo_in          = coo_ff;
      push            = 1'b0;
      push_cmd.pad    = 1'b0;
      push_cmd.target = TARGET_ELL;
      push_cmd.addr   = ell_addr;
      push_cmd.row    = row_ff[ROW_BITS-1:0];
      push_cmd.column = {1'b0, req_column_in};
      push_cmd.value  = req_entry_bits;
      push_cmd.count  = width_eff - pos_ff[WIDTH_BITS-1:0];
      if (req_func == FUNC_END_ROW) begin
         push_cmd.pad    = 1'b1;
         push_cmd.column = '1;
         push_cmd.value  = '0;
         push            = accept && is_ell;
         if (accept) begin
            row_in = row_ff + 1'b1;
            pos_in = '0;
         end
      end else begin
         push = accept;
         if (!is_ell) begin
            push_cmd.target = TARGET_COO;
            push_cmd.addr   = coo_ff;
         end
         if (accept) begin
            if (!is_ell) begin
               coo_in = coo_ff + 1'b1;
            end
            // long rows saturate
            if (pos_ff != '1) begin
               pos_in = pos_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         pos_ff <= '0;
         coo_ff <= '0;
      end else begin
         row_ff <= row_in;
         pos_ff <= pos_in;
         coo_ff <= coo_in;
      end
   end

   `CSR2HYB_ASSERT_NXT(a_row_close_clears_pos, accept && req_func == FUNC_END_ROW, pos_ff == '0, "position not cleared after end of row")

endmodule

>>> rtl/csr2hyb_queue.sv
`include "csr_to_hybrid_ell_coo_splitter_defines.svh"

module csr2hyb_queue
   import csr2hyb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_cmd
);

   cmd_type                   mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;

   assign full       = count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_cmd   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `CSR2HYB_ASSERT(a_count_bound, count_ff <= QUEUE_CNT_BITS'(QUEUE_DEPTH), "queue count overflow")
   `CSR2HYB_ASSERT_IMP(a_no_pop_empty, pop, count_ff != '0, "pop from empty queue")

endmodule

>>> rtl/csr2hyb_back.sv
`include "csr_to_hybrid_ell_coo_splitter_defines.svh"

module csr2hyb_back
   import csr2hyb_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    head_valid,
   input  cmd_type                 head_cmd,
   output logic                    pop,
   input  logic [STRIDE_BITS-1:0]  slot_stride,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_target,
   output logic [INDEX_BITS-1:0]   rsp_write_address,
   output logic [ROW_BITS-1:0]     rsp_row_out,
   output logic signed [INDEX_BITS-1:0] rsp_column_out,
   output logic [VALUE_BITS-1:0]   rsp_value_out,
   output logic                    rsp_last
);

   logic                  valid_ff, valid_in;
   target_type            target_ff, target_in;
   logic [INDEX_BITS-1:0] addr_ff, addr_in;
   logic [ROW_BITS-1:0]   row_ff, row_in;
   logic [INDEX_BITS-1:0] column_ff, column_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic                  last_ff, last_in;

   // padding run in progress
   logic [WIDTH_BITS-1:0] pad_rem_ff, pad_rem_in;
   logic [INDEX_BITS-1:0] pad_addr_ff, pad_addr_in;

   logic out_free;

   assign out_free = !valid_ff || rsp_ready;
   assign pop      = out_free && (pad_rem_ff == '0) && head_valid;

   always_comb begin
      valid_in    = valid_ff;
      target_in   = target_ff;
      addr_in     = addr_ff;
      row_in      = row_ff;
      column_in   = column_ff;
      value_in    = value_ff;
      last_in     = last_ff;
      pad_rem_in  = pad_rem_ff;
      pad_addr_in = pad_addr_ff;
      if (out_free) begin
         valid_in = 1'b0;
         if (pad_rem_ff != '0) begin
            valid_in    = 1'b1;
            target_in   = TARGET_ELL;
            addr_in     = pad_addr_ff;
            column_in   = '1;
            value_in    = '0;
            last_in     = pad_rem_ff == WIDTH_BITS'(1);
            pad_rem_in  = pad_rem_ff - 1'b1;
            pad_addr_in = pad_addr_ff + INDEX_BITS'(slot_stride);
         end else if (head_valid) begin
            valid_in  = 1'b1;
            target_in = head_cmd.target;
            addr_in   = head_cmd.addr;
            row_in    = head_cmd.row;
            column_in = head_cmd.column;
            value_in  = head_cmd.value;
            last_in   = 1'b1;
            if (head_cmd.pad) begin
               last_in     = head_cmd.count == WIDTH_BITS'(1);
               pad_rem_in  = head_cmd.count - 1'b1;
               pad_addr_in = head_cmd.addr + INDEX_BITS'(slot_stride);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         pad_rem_ff <= '0;
      end else begin
         valid_ff   <= valid_in;
         pad_rem_ff <= pad_rem_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff   <= target_in;
      addr_ff     <= addr_in;
      row_ff      <= row_in;
      column_ff   <= column_in;
      value_ff    <= value_in;
      last_ff     <= last_in;
      pad_addr_ff <= pad_addr_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_target        = target_ff;
   assign rsp_write_address = addr_ff;
   assign rsp_row_out       = row_ff;
   assign rsp_column_out    = column_ff;
   assign rsp_value_out     = value_ff;
   assign rsp_last          = last_ff;

   `CSR2HYB_ASSERT_IMP(a_pad_run_valid, pad_rem_ff != '0, valid_ff, "padding run without pending response")
   `CSR2HYB_ASSERT_IMP(a_pad_run_no_pop, pad_rem_ff != '0, !pop, "queue popped during padding run")

endmodule

>>> rtl/csr_to_hybrid_ell_coo_splitter.sv
// CSR to hybrid ELL/COO splitter.
// Request channel (req_*): one request per nonzero (req_func = 0, column and
// value bits) or one end-of-row marker (req_func = 1) closing each row.
// Response channel (rsp_*): write commands for the ELL or COO arrays; the
// first ell_width entries of a row (at most 16) go to ELL at row + slot
// stride * position, later ones to COO at a running pointer. An end-of-row
// marker yields one padding write (column -1, value 0) per unused ELL slot;
// rsp_last marks the last write caused by a request; full rows close silently.
// Config channel (csr_*): index 0 = ell_width, 1 = slot stride; write only
// while no request is in flight. csr_ready is always high.
// Throughput: one request per cycle for nonzeros while the queue has room; a
// padding run of n slots occupies the response register for n writes, one
// write per cycle while the receiver is ready. A request passes the command
// queue, then the response register; the 4-entry queue decouples the
// classifying front end from the response back end, so requests keep flowing
// while the receiver stalls until the queue fills; then req_ready drops.
// Reset (synchronous): row, position and COO pointer clear, ell_width = 0,
// slot stride = 1, queue and response register empty.
module csr_to_hybrid_ell_coo_splitter
   import csr2hyb_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [CSR_DATA_BITS-1:0]     csr_wdata,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_func,
   input  logic [COL_IN_BITS-1:0]       req_column_in,
   input  logic [VALUE_BITS-1:0]        req_entry_bits,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_target,
   output logic [INDEX_BITS-1:0]        rsp_write_address,
   output logic [ROW_BITS-1:0]          rsp_row_out,
   output logic signed [INDEX_BITS-1:0] rsp_column_out,
   output logic [VALUE_BITS-1:0]        rsp_value_out,
   output logic                         rsp_last
);

   logic [WIDTH_BITS-1:0]  ell_width_ff, ell_width_in;
   logic [STRIDE_BITS-1:0] slot_stride_ff, slot_stride_in;

   logic    queue_full;
   logic    push;
   cmd_type push_cmd;
   logic    pop;
   logic    head_valid;
   cmd_type head_cmd;

   assign csr_ready = 1'b1;

   always_comb begin
      ell_width_in   = ell_width_ff;
      slot_stride_in = slot_stride_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_ELL_WIDTH:   ell_width_in   = csr_wdata[WIDTH_BITS-1:0];
            CSR_SLOT_STRIDE: slot_stride_in = csr_wdata[STRIDE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ell_width_ff   <= '0;
         slot_stride_ff <= STRIDE_BITS'(1);
      end else begin
         ell_width_ff   <= ell_width_in;
         slot_stride_ff <= slot_stride_in;
      end
   end

   csr2hyb_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_column_in  (req_column_in),
      .req_entry_bits (req_entry_bits),
      .ell_width      (ell_width_ff),
      .slot_stride    (slot_stride_ff),
      .queue_full     (queue_full),
      .push           (push),
      .push_cmd       (push_cmd)
   );

   csr2hyb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   csr2hyb_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_cmd          (head_cmd),
      .pop               (pop),
      .slot_stride       (slot_stride_ff),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_target        (rsp_target),
      .rsp_write_address (rsp_write_address),
      .rsp_row_out       (rsp_row_out),
      .rsp_column_out    (rsp_column_out),
      .rsp_value_out     (rsp_value_out),
      .rsp_last          (rsp_last)
   );

endmodule

>>> tb/csr_to_hybrid_ell_coo_splitter_tb.sv
module csr_to_hybrid_ell_coo_splitter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import csr2hyb_pkg::*;

   localparam int SETTLE_CYCLES   = 8;
   localparam int HOLD_CYCLES     = 200;
   localparam int MAX_GAP         = 16;
   localparam int RANDOM_REQUESTS = 315;
   localparam int REPORT_LIMIT    = 10;

   typedef struct {
      target_type                  target;
      logic [INDEX_BITS-1:0]       address;
      logic [ROW_BITS-1:0]         row;
      logic signed [INDEX_BITS-1:0] column;
      logic [VALUE_BITS-1:0]       value;
      logic                        last;
   } hyb_write_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [CSR_INDEX_BITS-1:0]     csr_index = '0;
   logic [CSR_DATA_BITS-1:0]      csr_wdata = '0;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic                          req_func = 1'b0;
   logic [COL_IN_BITS-1:0]        req_column_in = '0;
   logic [VALUE_BITS-1:0]         req_entry_bits = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic                          rsp_target;
   logic [INDEX_BITS-1:0]         rsp_write_address;
   logic [ROW_BITS-1:0]           rsp_row_out;
   logic signed [INDEX_BITS-1:0]  rsp_column_out;
   logic [VALUE_BITS-1:0]         rsp_value_out;
   logic                          rsp_last;

   // shadow of the block's registers and row state
   logic [WIDTH_BITS-1:0]  cfg_width = '0;
   logic [STRIDE_BITS-1:0] cfg_stride = 31'd1;
   logic [INDEX_BITS-1:0]  cur_row = '0;
   logic [INDEX_BITS-1:0]  row_fill = '0;
   logic [INDEX_BITS-1:0]  coo_next = '0;

   hyb_write_type pending_writes[$];
   int unsigned error_count = 0;
   int unsigned requests_sent = 0;
   bit          tx_idle_on = 1'b1;
   logic        rx_idle_on = 1'b1;
   logic        hold_rsp = 1'b0;
   int unsigned rsp_gap = 0;

   csr_to_hybrid_ell_coo_splitter i_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_column_in     (req_column_in),
      .req_entry_bits    (req_entry_bits),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_target        (rsp_target),
      .rsp_write_address (rsp_write_address),
      .rsp_row_out       (rsp_row_out),
      .rsp_column_out    (rsp_column_out),
      .rsp_value_out     (rsp_value_out),
      .rsp_last          (rsp_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Expected ELL/COO writes for one accepted request.
   task automatic predict_writes(input func_type func, input logic [COL_IN_BITS-1:0] column,
                                 input logic [VALUE_BITS-1:0] bits);
      hyb_write_type         w;
      logic [INDEX_BITS-1:0] slots;
      logic [INDEX_BITS-1:0] pos;
      slots = (cfg_width > MAX_ELL_WIDTH) ? MAX_ELL_WIDTH : INDEX_BITS'(cfg_width);
      w.row = cur_row[ROW_BITS-1:0];
      if (func == FUNC_ENTRY) begin
         w.column = {1'b0, column};
         w.value  = bits;
         w.last   = 1'b1;
         if (row_fill < slots) begin
            w.target  = TARGET_ELL;
            w.address = cur_row + {1'b0, cfg_stride} * row_fill;
         end else begin
            w.target  = TARGET_COO;
            w.address = coo_next;
            coo_next++;
         end
         if (row_fill != '1) row_fill++;
         pending_writes.push_back(w);
      end else begin
         // pad the unused ELL slots, last flag on the final one
         for (pos = row_fill; pos < slots; pos++) begin
            w.target  = TARGET_ELL;
            w.address = cur_row + {1'b0, cfg_stride} * pos;
            w.column  = '1;
            w.value   = '0;
            w.last    = (pos + 1 == slots);
            pending_writes.push_back(w);
         end
         cur_row++;
         row_fill = '0;
      end
   endtask

   function automatic logic [COL_IN_BITS-1:0] rand_column();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return COL_IN_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [VALUE_BITS-1:0] rand_bits();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Called at a rising edge; returns at the edge that accepted the request.
   task automatic send_request(input func_type func, input logic [COL_IN_BITS-1:0] column,
                               input logic [VALUE_BITS-1:0] bits);
      int unsigned gap;
      gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= func;
      req_column_in  <= column;
      req_entry_bits <= bits;
      do @(posedge clock); while (!req_ready);
      predict_writes(func, column, bits);
      requests_sent++;
   endtask

   task automatic send_row(input int unsigned entries);
      repeat (entries) send_request(FUNC_ENTRY, rand_column(), rand_bits());
      send_request(FUNC_END_ROW, rand_column(), rand_bits());
   endtask

   // Stop sending, let every expected write arrive, then give a silent row
   // close time to finish in the front end.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes both registers back to back; valid stays high between them.
   task automatic configure(input logic [WIDTH_BITS-1:0] width,
                            input logic [STRIDE_BITS-1:0] stride);
      csr_valid <= 1'b1;
      csr_index <= CSR_ELL_WIDTH;
      csr_wdata <= {{(CSR_DATA_BITS-WIDTH_BITS){1'b0}}, width};
      do @(posedge clock); while (!csr_ready);
      cfg_width = width;
      csr_index <= CSR_SLOT_STRIDE;
      csr_wdata <= stride;
      do @(posedge clock); while (!csr_ready);
      cfg_stride = stride;
      csr_valid <= 1'b0;
   endtask

   task automatic test_row_shapes();
      configure(5'd4, 31'd16);
      // partial row: extremes of column and value, two padding slots
      send_request(FUNC_ENTRY, '0, '0);
      send_request(FUNC_ENTRY, '1, '1);
      send_request(FUNC_END_ROW, '1, '1);
      send_row(4);   // full row closes silently
      send_row(6);   // spills into COO
      send_row(0);   // empty row, all padding
   endtask

   task automatic test_width_extremes();
      wait_for_drain();
      configure(5'd0, 31'd1);
      send_row(1);
      wait_for_drain();
      configure(5'd31, 31'd1);   // clamps to the maximum width
      send_row(0);
      send_row(1);
   endtask

   task automatic test_stride_extremes();
      wait_for_drain();
      configure(5'd3, 31'd0);    // every slot of a row on one address
      send_row(1);
      wait_for_drain();
      configure(5'd16, '1);      // addresses wrap
      send_row(1);
   endtask

   task automatic test_output_stall();
      wait_for_drain();
      configure(5'd4, 31'd64);
      tx_idle_on = 1'b0;
      rx_idle_on <= 1'b0;
      fork
         begin
            hold_rsp <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp <= 1'b0;
         end
         send_row(24);
      join
   endtask

   task automatic test_sender_pause();
      tx_idle_on = 1'b1;
      rx_idle_on <= 1'b1;
      wait_for_drain();
      send_row(3);
   endtask

   task automatic test_random_rows();
      int unsigned           goal;
      int unsigned           slots;
      logic [WIDTH_BITS-1:0] width;
      logic [STRIDE_BITS-1:0] stride;
      goal = requests_sent + RANDOM_REQUESTS;
      while (requests_sent < goal) begin
         wait_for_drain();
         case ($urandom_range(0, 5))
            0: width = '0;
            1: width = 5'd16;
            2: width = WIDTH_BITS'($urandom_range(17, 31));
            default: width = WIDTH_BITS'($urandom_range(1, 15));
         endcase
         case ($urandom_range(0, 5))
            0: stride = '0;
            1: stride = 31'd1;
            2: stride = '1;
            3: stride = STRIDE_BITS'($urandom);
            default: stride = STRIDE_BITS'($urandom_range(1, 64));
         endcase
         configure(width, stride);
         tx_idle_on = ($urandom_range(0, 3) != 0);
         rx_idle_on <= ($urandom_range(0, 3) != 0);
         slots = (width > MAX_ELL_WIDTH) ? MAX_ELL_WIDTH : width;
         repeat ($urandom_range(2, 6)) begin
            if ($urandom_range(0, 7) == 0) send_row($urandom_range(0, slots + 12));
            else send_row($urandom_range(0, slots + 3));
         end
      end
   endtask

   // receiver: random stall after each accepted write, plus the long hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_gap = 0;
      end else begin
         if (rsp_valid && rsp_ready) rsp_gap = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
         else if (rsp_gap != 0) rsp_gap--;
         rsp_ready <= (rsp_gap == 0) && !hold_rsp;
      end
   end

   always @(posedge clock) begin
      hyb_write_type got;
      hyb_write_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.target  = target_type'(rsp_target);
         got.address = rsp_write_address;
         got.row     = rsp_row_out;
         got.column  = rsp_column_out;
         got.value   = rsp_value_out;
         got.last    = rsp_last;
         if (pending_writes.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("%0t: unexpected write tgt=%0d addr=%h row=%h col=%h val=%h last=%b",
                        $realtime, got.target, got.address, got.row, got.column, got.value,
                        got.last);
         end else begin
            want = pending_writes.pop_front();
            if (got.target !== want.target || got.address !== want.address ||
                got.row !== want.row || got.column !== want.column ||
                got.value !== want.value || got.last !== want.last) begin
               error_count++;
               if (error_count <= REPORT_LIMIT) begin
                  $display("%0t: write mismatch", $realtime);
                  $display("   expected tgt=%0d addr=%h row=%h col=%h val=%h last=%b",
                           want.target, want.address, want.row, want.column, want.value,
                           want.last);
                  $display("   actual   tgt=%0d addr=%h row=%h col=%h val=%h last=%b",
                           got.target, got.address, got.row, got.column, got.value, got.last);
               end
            end
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_row_shapes();
      test_width_extremes();
      test_stride_extremes();
      test_output_stall();
      test_sender_pause();
      test_random_rows();
      wait_for_drain();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
